FILE: hw/rtl/kmc_pkg.sv
package kmc_pkg;

  // fixed field widths
  localparam int unsigned CELL_W = 12;
  localparam int unsigned SIDE_W = 7;
  localparam int unsigned GRID_W = 8;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // default table depth
  localparam int unsigned MAX_CELLS_DEF = 4096;

  // largest usable side and saturating rank
  localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(64);
  localparam logic [RANK_W-1:0] RANK_LIMIT = RANK_W'(15);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_ACROSS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_DOWN   = 1'b1;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_LIMIT) begin
      r = SIDE_LIMIT;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/kruskal_maze_carver.sv
// kruskal maze carver: union-find over the cells of a maze, one candidate edge per transaction
//
// input channel: first_cell_i, second_cell_i and start_maze_i are taken at a rising edge where
//   start is high and busy is low. start_maze_i puts every cell back in its own set first.
// result channel: done_o is high for exactly one cycle with carved_o, wall_row_o, wall_col_o
//   and bad_edge_o; the receiver cannot hold results off, so it must take them in that cycle.
// config port: cfg_we_i writes cfg_wdata_i to cells_across (index 0) or cells_down (index 1)
//   at the edge, with no wait; write only while busy is low.
// sequence: a range check, restoring division of the first cell by the width (one quotient
//   bit per cycle through a single subtractor), a classify step, then two root walks through
//   the parent memory's single read port, and the rank reads and union. A cell out of range
//   ends the transaction after the check, cells that are not neighbors after the classify
//   step and cells already joined after the second walk; union by rank keeps a tree at most
//   12 deep with 4096 cells. A new transaction is taken from the strobe cycle on; one edge
//   at a time.
// reset: the parent and rank memories are swept, one entry per cycle, through all MAX_CELLS
//   entries (4096 by default) while busy stays high; config writes are taken as usual. A
//   transaction with start_maze_i set runs the same sweep first.
// roots are found without rewriting the walked path; union by rank keeps paths short and the
//   set membership, which is all the results depend on, is the same either way.
module kruskal_maze_carver #(
  parameter int unsigned MAX_CELLS = kmc_pkg::MAX_CELLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [kmc_pkg::CELL_W-1:0]     first_cell_i,
  input  logic [kmc_pkg::CELL_W-1:0]     second_cell_i,
  input  logic                           start_maze_i,
  output logic                           done_o,
  output logic                           carved_o,
  output logic [kmc_pkg::GRID_W-1:0]     wall_row_o,
  output logic [kmc_pkg::GRID_W-1:0]     wall_col_o,
  output logic                           bad_edge_o,
  input  logic                           cfg_we_i,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kmc_pkg::SIDE_W-1:0]     cfg_wdata_i
);
  import kmc_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CELLS);
  localparam int unsigned LIM_W = CELL_W + 1;
  // cell indices never exceed the 12 bit field, so the bound is the smaller of the two
  localparam int unsigned LIMIT_CAP = (MAX_CELLS < (1 << CELL_W)) ? MAX_CELLS : (1 << CELL_W);
  localparam int unsigned DIV_CNT_W = $clog2(CELL_W);
  localparam int unsigned ROW_W = SIDE_W - 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_CLASSIFY,
    ST_FIND,
    ST_WALK,
    ST_RANK_A,
    ST_RANK_B,
    ST_UNITE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [SIDE_W-1:0] across_q, down_q;

  // transaction registers
  logic [CELL_W-1:0]    a_q, b_q;
  logic                 pend_q;       // sweep was asked for by start_maze
  logic [SIDE_W-1:0]    w_q;
  logic [CELL_W-1:0]    quo_q;        // dividend shifting out, quotient shifting in
  logic [ROW_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [IDX_W-1:0]     cur_q;
  logic                 second_q;     // walking from the second cell
  logic [IDX_W-1:0]     root_a_q, root_b_q;
  logic [RANK_W-1:0]    rank_a_q;
  logic [IDX_W-1:0]     clr_cnt_q;

  // result registers
  logic                 done_q, carved_q, bad_q;
  logic [GRID_W-1:0]    row_q, col_q;

  // memories
  logic [IDX_W-1:0]  par_mem [MAX_CELLS];
  logic [RANK_W-1:0] rank_mem [MAX_CELLS];
  logic [IDX_W-1:0]  par_rdata_q;
  logic [RANK_W-1:0] rank_rdata_q;

  logic              par_we, rank_we;
  logic [IDX_W-1:0]  par_waddr, par_wdata, par_raddr, rank_waddr, rank_raddr;
  logic [RANK_W-1:0] rank_wdata;

  // datapath
  logic [SIDE_W-1:0] w_eff, h_eff;
  logic [LIM_W-1:0]  limit;
  logic              out_of_range;
  logic [SIDE_W-1:0] div_t;
  logic              div_ge;
  logic [ROW_W-1:0]  ra, ca;
  logic              is_vert, is_horiz;
  logic              a_lower;

  assign w_eff = eff_side(across_q);
  assign h_eff = eff_side(down_q);

  always_comb begin
    logic [2*SIDE_W-1:0] prod;
    prod = w_eff * h_eff;
    limit = LIM_W'(prod);
    if (limit > LIM_W'(LIMIT_CAP)) begin
      limit = LIM_W'(LIMIT_CAP);
    end
  end

  assign out_of_range = ({1'b0, a_q} >= limit) || ({1'b0, b_q} >= limit);

  // one restoring division step
  assign div_t  = {rem_q, quo_q[CELL_W-1]};
  assign div_ge = div_t >= w_q;

  // quotient stays below the height and remainder below the width
  assign ra = quo_q[ROW_W-1:0];
  assign ca = rem_q;

  assign is_vert  = {1'b0, b_q} == ({1'b0, a_q} + LIM_W'(w_q));
  assign is_horiz = ({1'b0, b_q} == ({1'b0, a_q} + LIM_W'(1)))
                    && ((SIDE_W'(ca) + SIDE_W'(1)) < w_q);

  assign a_lower = rank_a_q < rank_rdata_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= SIDE_LIMIT;
      down_q   <= SIDE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CELLS_ACROSS: across_q <= cfg_wdata_i;
        CFG_CELLS_DOWN:   down_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // memory port control
  always_comb begin
    par_we     = 1'b0;
    par_waddr  = clr_cnt_q;
    par_wdata  = clr_cnt_q;
    rank_we    = 1'b0;
    rank_waddr = clr_cnt_q;
    rank_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        par_we  = 1'b1;
        rank_we = 1'b1;
      end
      ST_UNITE: begin
        par_we = 1'b1;
        if (a_lower) begin
          par_waddr = root_a_q;
          par_wdata = root_b_q;
        end else begin
          par_waddr = root_b_q;
          par_wdata = root_a_q;
        end
        rank_waddr = root_a_q;
        rank_wdata = rank_a_q + RANK_W'(1);
        rank_we    = (rank_a_q == rank_rdata_q) && (rank_a_q < RANK_LIMIT);
      end
      default: ;
    endcase
  end

  assign par_raddr  = (state_q == ST_WALK) ? par_rdata_q : cur_q;
  assign rank_raddr = (state_q == ST_RANK_A) ? root_a_q : root_b_q;

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rdata_q <= par_mem[par_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata_q <= rank_mem[rank_raddr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
      carved_q  <= 1'b0;
      bad_q     <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      a_q       <= '0;
      b_q       <= '0;
      w_q       <= '0;
      quo_q     <= '0;
      rem_q     <= '0;
      div_cnt_q <= '0;
      cur_q     <= '0;
      second_q  <= 1'b0;
      root_a_q  <= '0;
      root_b_q  <= '0;
      rank_a_q  <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_cnt_q == IDX_W'(MAX_CELLS - 1)) begin
            clr_cnt_q <= '0;
            pend_q    <= 1'b0;
            state_q   <= pend_q ? ST_CHECK : ST_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          // the strobe lasts the one idle cycle after a transaction
          done_q <= 1'b0;
          if (start) begin
            a_q     <= first_cell_i;
            b_q     <= second_cell_i;
            pend_q  <= start_maze_i;
            state_q <= start_maze_i ? ST_CLEAR : ST_CHECK;
          end
        end
        ST_CHECK: begin
          w_q       <= w_eff;
          quo_q     <= a_q;
          rem_q     <= '0;
          div_cnt_q <= '0;
          if (out_of_range) begin
            done_q   <= 1'b1;
            carved_q <= 1'b0;
            bad_q    <= 1'b1;
            row_q    <= '0;
            col_q    <= '0;
            state_q  <= ST_IDLE;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_q     <= {quo_q[CELL_W-2:0], div_ge};
          rem_q     <= div_ge ? ROW_W'(div_t - w_q) : div_t[ROW_W-1:0];
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(CELL_W - 1)) begin
            state_q <= ST_CLASSIFY;
          end
        end
        ST_CLASSIFY: begin
          cur_q    <= IDX_W'(a_q);
          second_q <= 1'b0;
          if (!is_vert && !is_horiz) begin
            done_q   <= 1'b1;
            carved_q <= 1'b0;
            bad_q    <= 1'b1;
            row_q    <= '0;
            col_q    <= '0;
            state_q  <= ST_IDLE;
          end else if (is_vert) begin
            row_q   <= GRID_W'({ra, 1'b0}) + GRID_W'(2);
            col_q   <= GRID_W'({ca, 1'b1});
            state_q <= ST_FIND;
          end else begin
            row_q   <= GRID_W'({ra, 1'b1});
            col_q   <= GRID_W'({ca, 1'b0}) + GRID_W'(2);
            state_q <= ST_FIND;
          end
        end
        ST_FIND: begin
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (par_rdata_q == cur_q) begin
            if (!second_q) begin
              root_a_q <= cur_q;
              cur_q    <= IDX_W'(b_q);
              second_q <= 1'b1;
              state_q  <= ST_FIND;
            end else begin
              root_b_q <= cur_q;
              if (cur_q == root_a_q) begin
                done_q   <= 1'b1;
                carved_q <= 1'b0;
                bad_q    <= 1'b0;
                row_q    <= '0;
                col_q    <= '0;
                state_q  <= ST_IDLE;
              end else begin
                state_q <= ST_RANK_A;
              end
            end
          end else begin
            cur_q <= par_rdata_q;
          end
        end
        ST_RANK_A: begin
          state_q <= ST_RANK_B;
        end
        ST_RANK_B: begin
          rank_a_q <= rank_rdata_q;
          state_q  <= ST_UNITE;
        end
        ST_UNITE: begin
          done_q   <= 1'b1;
          carved_q <= 1'b1;
          bad_q    <= 1'b0;
          state_q  <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = state_q != ST_IDLE;
  assign done_o     = done_q;
  assign carved_o   = carved_q;
  assign bad_edge_o = bad_q;
  assign wall_row_o = row_q;
  assign wall_col_o = col_q;

  // a wall is reported only together with a carve
  a_wall_only_when_carved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !carved_o |-> wall_row_o == '0 && wall_col_o == '0)
    else $error("wall reported without carve");

  // carve and bad edge exclude each other
  a_carve_not_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(carved_o && bad_edge_o))
    else $error("carved and bad_edge together");

  // a union only ever joins two distinct roots
  a_unite_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UNITE |-> root_a_q != root_b_q)
    else $error("union of a set with itself");

  // the result strobe comes as the block returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe outside end of transaction");

  // an accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("transaction accepted without going busy");

endmodule

FILE: test/kruskal_maze_carver_tb.sv
module kruskal_maze_carver_tb;
  import kmc_pkg::*;

  // table depth of the instance and the mirror tables below
  localparam int unsigned TABLE_DEPTH = kmc_pkg::MAX_CELLS_DEF;
  // random transactions after the directed part
  localparam int unsigned RANDOM_ITEMS = 500;
  // longest walk through a shuffled maze before the next one starts
  localparam int unsigned MAZE_CAP = 60;
  // rank saturates here
  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(15);
  // largest side the block honors
  localparam int unsigned SIDE_TOP = 64;

  typedef logic [CELL_W-1:0] cell_t;

  // one wall report as it leaves the block
  typedef struct packed {
    logic              carved;
    logic [GRID_W-1:0] wall_row;
    logic [GRID_W-1:0] wall_col;
    logic              bad_edge;
  } wall_t;

  // one candidate pair of cells
  typedef struct {
    cell_t upper;
    cell_t lower;
  } pair_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  cell_t              first_cell_i = '0;
  cell_t              second_cell_i = '0;
  logic               start_maze_i = 1'b0;
  logic               done_o;
  logic               carved_o;
  logic [GRID_W-1:0]  wall_row_o;
  logic [GRID_W-1:0]  wall_col_o;
  logic               bad_edge_o;
  logic               cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [SIDE_W-1:0]  cfg_wdata_i = '0;

  // mirror of the union-find state and the two size registers
  cell_t              link_up [TABLE_DEPTH];
  logic [RANK_W-1:0]  tree_height [TABLE_DEPTH];
  logic [SIDE_W-1:0]  across_q = SIDE_W'(64);
  logic [SIDE_W-1:0]  down_q = SIDE_W'(64);

  // wall reports still owed by the block, oldest first
  wall_t              pending_walls [$];
  // shuffled pairs of the maze being carved
  pair_t              maze_links [$];

  int unsigned        mismatch_cnt = 0;
  int unsigned        items_sent = 0;
  int unsigned        burst_left = 0;

  kruskal_maze_carver #(
    .MAX_CELLS(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .first_cell_i (first_cell_i),
    .second_cell_i(second_cell_i),
    .start_maze_i (start_maze_i),
    .done_o       (done_o),
    .carved_o     (carved_o),
    .wall_row_o   (wall_row_o),
    .wall_col_o   (wall_col_o),
    .bad_edge_o   (bad_edge_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // every cell back in a set of its own
  function automatic void split_all();
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      link_up[i] = cell_t'(i);
      tree_height[i] = '0;
    end
  endfunction

  // zero reads as one, anything past the top reads as the top
  function automatic int unsigned side_used(logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIDE_TOP) return SIDE_TOP;
    return v;
  endfunction

  // set root with path compression; membership is what matters, so the
  // block is free to skip the compression
  function automatic cell_t set_head(cell_t x);
    cell_t head;
    cell_t nxt;
    head = x;
    while (link_up[head] != head) head = link_up[head];
    while (x != head) begin
      nxt = link_up[x];
      link_up[x] = head;
      x = nxt;
    end
    return head;
  endfunction

  // expected wall report for one candidate, updating the mirror tables
  function automatic wall_t carve_edge(cell_t a, cell_t b, logic clr);
    wall_t       res;
    int unsigned w;
    int unsigned h;
    int unsigned span;
    int unsigned row_first;
    int unsigned col_first;
    logic        vert;
    logic        horiz;
    cell_t       head_a;
    cell_t       head_b;
    res = '0;
    w = side_used(across_q);
    h = side_used(down_q);
    // a start_maze clear comes first, even for a bad pair
    if (clr) split_all();
    span = w * h;
    if (span > TABLE_DEPTH) span = TABLE_DEPTH;
    if (a >= span || b >= span) begin
      res.bad_edge = 1'b1;
      return res;
    end
    row_first = a / w;
    col_first = a % w;
    // with a width of one the next index is the cell below
    vert = (b == a + w);
    horiz = !vert && (b == a + 1) && (col_first + 1 < w);
    if (!vert && !horiz) begin
      res.bad_edge = 1'b1;
      return res;
    end
    head_a = set_head(a);
    head_b = set_head(b);
    // same set: no wall comes down
    if (head_a == head_b) return res;
    // union by rank, rank saturating
    if (tree_height[head_a] < tree_height[head_b]) begin
      link_up[head_a] = head_b;
    end else if (tree_height[head_a] > tree_height[head_b]) begin
      link_up[head_b] = head_a;
    end else begin
      link_up[head_b] = head_a;
      if (tree_height[head_a] < RANK_TOP) tree_height[head_a]++;
    end
    res.carved = 1'b1;
    if (vert) begin
      res.wall_row = GRID_W'(2 * row_first + 2);
      res.wall_col = GRID_W'(2 * col_first + 1);
    end else begin
      res.wall_row = GRID_W'(2 * row_first + 1);
      res.wall_col = GRID_W'(2 * col_first + 2);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every strobe is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : wall_check
    wall_t got;
    wall_t want;
    if (done_o) begin
      got = '{carved_o, wall_row_o, wall_col_o, bad_edge_o};
      if (pending_walls.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected wall report: carved %0d row %0d col %0d bad %0d",
                   got.carved, got.wall_row, got.wall_col, got.bad_edge);
      end else begin
        want = pending_walls.pop_front();
        if (got.carved !== want.carved || got.wall_row !== want.wall_row ||
            got.wall_col !== want.wall_col || got.bad_edge !== want.bad_edge) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch carved/row/col/bad: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     want.carved, want.wall_row, want.wall_col, want.bad_edge,
                     got.carved, got.wall_row, got.wall_col, got.bad_edge);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one transaction; the sender runs in bursts with random gaps between them
  task automatic send_pair(input cell_t a, input cell_t b, input logic clr);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    start <= 1'b1;
    first_cell_i <= a;
    second_cell_i <= b;
    start_maze_i <= clr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // taken at this edge
    pending_walls.push_back(carve_edge(a, b, clr));
    items_sent++;
    burst_left--;
  endtask

  // hold off until every owed report is in and the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_walls.size() != 0 || busy) @(posedge clk_i);
  endtask

  // both size registers, back to back; only called while idle
  task automatic write_regs(input logic [SIDE_W-1:0] across, input logic [SIDE_W-1:0] down);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CELLS_ACROSS;
    cfg_wdata_i <= across;
    @(posedge clk_i);
    across_q = across;
    cfg_idx_i <= CFG_CELLS_DOWN;
    cfg_wdata_i <= down;
    @(posedge clk_i);
    down_q = down;
    cfg_we_i <= 1'b0;
  endtask

  // a junk or repeated pair, now and then with a clear in front
  task automatic send_noise();
    int unsigned span;
    cell_t       a;
    cell_t       b;
    pair_t       old;
    span = side_used(across_q) * side_used(down_q);
    if (span > TABLE_DEPTH) span = TABLE_DEPTH;
    case ($urandom_range(0, 2))
      0: begin
        a = cell_t'($urandom_range(0, TABLE_DEPTH - 1));
        b = cell_t'($urandom_range(0, TABLE_DEPTH - 1));
      end
      1: begin
        a = cell_t'($urandom_range(0, span - 1));
        b = cell_t'(a + $urandom_range(0, side_used(across_q) + 1));
      end
      default: begin
        if (maze_links.size() != 0) begin
          old = maze_links[$urandom_range(0, maze_links.size() - 1)];
          a = old.upper;
          b = old.lower;
        end else begin
          a = cell_t'($urandom_range(0, span - 1));
          b = a;
        end
      end
    endcase
    send_pair(a, b, $urandom_range(0, 39) == 0);
  endtask

  // walls of the current grid in random order, at most MAZE_CAP of them, opened by a clear
  task automatic carve_random_maze();
    int unsigned w;
    int unsigned h;
    int unsigned idx;
    int unsigned j;
    int unsigned n;
    pair_t       p;
    pair_t       tmp;
    w = side_used(across_q);
    h = side_used(down_q);
    maze_links.delete();
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        idx = r * w + c;
        if (idx + w < TABLE_DEPTH || c + 1 < w) begin
          if (c + 1 < w) begin
            p.upper = cell_t'(idx);
            p.lower = cell_t'(idx + 1);
            maze_links.push_back(p);
          end
          if (r + 1 < h) begin
            p.upper = cell_t'(idx);
            p.lower = cell_t'(idx + w);
            maze_links.push_back(p);
          end
        end
      end
    end
    for (int i = maze_links.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = maze_links[i];
      maze_links[i] = maze_links[j];
      maze_links[j] = tmp;
    end
    // a one-cell grid has no walls: a clear on a junk pair instead
    if (maze_links.size() == 0) begin
      send_pair(cell_t'($urandom_range(0, TABLE_DEPTH - 1)), '0, 1'b1);
      return;
    end
    n = (maze_links.size() < MAZE_CAP) ? maze_links.size() : MAZE_CAP;
    for (int unsigned i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(0, 6) == 0) send_noise();
      send_pair(maze_links[i].upper, maze_links[i].lower, i == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // 64 by 64 grid out of reset: both wall kinds, same set, far corner
  task automatic test_default_grid();
    send_pair(12'd0, 12'd1, 1'b0);
    send_pair(12'd0, 12'd64, 1'b0);
    send_pair(12'd1, 12'd65, 1'b0);
    // closes a loop, nothing to carve
    send_pair(12'd64, 12'd65, 1'b0);
    send_pair(12'd4094, 12'd4095, 1'b0);
    send_pair(12'd4031, 12'd4095, 1'b0);
  endtask

  // pairs that are not neighbours, and a clear riding on a bad pair
  task automatic test_bad_pairs();
    // end of one row to the start of the next
    send_pair(12'd63, 12'd64, 1'b0);
    send_pair(12'd0, 12'd2, 1'b0);
    send_pair(12'd5, 12'd5, 1'b0);
    send_pair(12'd65, 12'd1, 1'b0);
    send_pair(12'd4095, 12'd0, 1'b0);
    // clear still applies, so the next pair carves again
    send_pair(12'd7, 12'd7, 1'b1);
    send_pair(12'd0, 12'd1, 1'b0);
  endtask

  // register extremes: zero width, oversized sides, out of range cells
  task automatic test_size_regs();
    wait_idle();
    // width zero reads as one, so the next index is the cell below
    write_regs(SIDE_W'(0), SIDE_W'(5));
    send_pair(12'd0, 12'd1, 1'b0);
    send_pair(12'd3, 12'd4, 1'b0);
    send_pair(12'd4, 12'd5, 1'b0);
    send_pair(12'd2, 12'd4, 1'b0);
    wait_idle();
    // oversized reads as 64
    write_regs(SIDE_W'(127), SIDE_W'(127));
    send_pair(12'd0, 12'd64, 1'b1);
    wait_idle();
    write_regs(SIDE_W'(3), SIDE_W'(1));
    send_pair(12'd1, 12'd2, 1'b0);
    send_pair(12'd2, 12'd3, 1'b0);
    wait_idle();
    // one row of 64, height zero
    write_regs(SIDE_W'(64), SIDE_W'(0));
    send_pair(12'd62, 12'd63, 1'b0);
    send_pair(12'd0, 12'd64, 1'b0);
  endtask

  // shuffled mazes over a spread of grid sizes with junk mixed in
  task automatic test_random_mazes();
    int unsigned base;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      // the sender drains fully before each new grid
      wait_idle();
      case ($urandom_range(0, 9))
        0: write_regs(SIDE_W'($urandom_range(0, 1) ? 127 : $urandom_range(0, 1)),
                      SIDE_W'($urandom_range(0, 1) ? 0 : $urandom_range(65, 127)));
        1: write_regs(SIDE_W'(64), SIDE_W'(64));
        2: write_regs(SIDE_W'(1), SIDE_W'($urandom_range(2, 16)));
        3: write_regs(SIDE_W'($urandom_range(9, 63)), SIDE_W'($urandom_range(1, 4)));
        default: write_regs(SIDE_W'($urandom_range(2, 8)), SIDE_W'($urandom_range(2, 8)));
      endcase
      repeat ($urandom_range(1, 3)) carve_random_maze();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    split_all();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block sweeps its tables after reset; sends simply wait on busy
    test_default_grid();
    test_bad_pairs();
    test_size_regs();
    test_random_mazes();
    wait_idle();
    // quiet tail to catch stray strobes
    repeat (64) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("kruskal_maze_carver_tb: done, clean");
    end else begin
      $display("kruskal_maze_carver_tb: done, errors");
    end
    $finish;
  end

  // watchdog, several times the slowest expected run including table sweeps
  initial begin
    #200_000_000;
    $display("kruskal_maze_carver_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/kmc_pkg.sv
hw/rtl/kruskal_maze_carver.sv
test/kruskal_maze_carver_tb.sv
